// File: sv/atp_pkg.sv
`timescale 1ns / 1ps
package atp_pkg;

  localparam int QueueDepthDefault = 2;
  localparam logic [7:0] PayloadLimitReset = 8'd31;

  // characters
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChA       = 8'h41;
  localparam logic [7:0] ChC       = 8'h43;
  localparam logic [7:0] ChK       = 8'h4B;

  // line status codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StRcv     = 3'd1;
  localparam logic [2:0] StRcvAck  = 3'd2;
  localparam logic [2:0] StRcvFmt  = 3'd3;
  localparam logic [2:0] StErr     = 3'd4;
  localparam logic [2:0] StReady   = 3'd5;
  localparam logic [2:0] StFactory = 3'd6;
  localparam logic [2:0] StUnknown = 3'd7;

  // prefix candidate indexes
  localparam int NumPrefix = 5;
  localparam int CandOk      = 0;
  localparam int CandRcv     = 1;
  localparam int CandErr     = 2;
  localparam int CandReady   = 3;
  localparam int CandFactory = 4;

  // register map
  localparam logic RegPayloadLimit = 1'b0;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_digit;
    logic       is_comma;
    logic       is_newline;
    logic       is_plus;
    logic       is_equals;
  } rx_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pchar;
    logic [7:0]  ppos;
    logic [2:0]  status;
    logic [15:0] id;
    logic [7:0]  len;
    logic [7:0]  rssi;
    logic [7:0]  snr;
    logic        err;
  } rec_t;

  // prefix text, position 0 is the plus sign
  function automatic logic [7:0] prefix_char(input int k, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      CandOk: begin
        unique case (pos)
          4'd1: c = 8'h4F;
          4'd2: c = 8'h4B;
          default: c = 8'h00;
        endcase
      end
      CandRcv: begin
        unique case (pos)
          4'd1: c = 8'h52;
          4'd2: c = 8'h43;
          4'd3: c = 8'h56;
          default: c = 8'h00;
        endcase
      end
      CandErr: begin
        unique case (pos)
          4'd1: c = 8'h45;
          4'd2: c = 8'h52;
          4'd3: c = 8'h52;
          default: c = 8'h00;
        endcase
      end
      CandReady: begin
        unique case (pos)
          4'd1: c = 8'h52;
          4'd2: c = 8'h45;
          4'd3: c = 8'h41;
          4'd4: c = 8'h44;
          4'd5: c = 8'h59;
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          4'd1: c = 8'h46;
          4'd2: c = 8'h41;
          4'd3: c = 8'h43;
          4'd4: c = 8'h54;
          4'd5: c = 8'h4F;
          4'd6: c = 8'h52;
          4'd7: c = 8'h59;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [3:0] prefix_len(input int k);
    logic [3:0] n;
    unique case (k)
      CandOk:    n = 4'd3;
      CandRcv:   n = 4'd4;
      CandErr:   n = 4'd4;
      CandReady: n = 4'd6;
      default:   n = 4'd8;
    endcase
    return n;
  endfunction

  // decimal accumulate with saturation
  function automatic logic [7:0] acc8(input logic [7:0] v, input logic [3:0] d);
    logic [11:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'h00, d};
    return (n > 12'd255) ? 8'hFF : n[7:0];
  endfunction

  function automatic logic [15:0] acc16(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'h0000, d};
    return (n > 20'd65535) ? 16'hFFFF : n[15:0];
  endfunction

endpackage

// File: sv/at_response_line_parser.sv
`timescale 1ns / 1ps
// reply line parser for a text-command serial radio module
// input channel: in_valid / in_ready with rx_byte, one received character per
//   transaction
// output channel: out_valid / out_ready with one record per transaction:
//   record_kind 0 carries a copied payload character and its position,
//   record_kind 1 is the end-of-line status record (status, id, length,
//   rssi, snr and the sticky error mark)
// config: apb-style port, payload_limit at byte address 0 (reset 31);
//   write it only while no line is in flight
// an accepted character is written into the queue; the back end pops it and
//   registers any record that it produces, raising out_valid with it
// throughput: one character per cycle while the output is not stalled; the
//   back end parses, the front classifies and feeds a two-entry queue
// reset: the parser returns to hunting for '+', the queue and the output
//   register empty, the error mark clears and payload_limit returns to 31
// a stalled receiver holds the output record; the queue keeps taking
//   characters until it is full, then in_ready drops
module at_response_line_parser import atp_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        record_kind,
  output logic [7:0]  payload_char,
  output logic [7:0]  payload_pos,
  output logic [2:0]  line_status,
  output logic [15:0] sender_id,
  output logic [7:0]  declared_length,
  output logic [7:0]  rssi_magnitude,
  output logic [7:0]  snr_value,
  output logic        error_seen,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       payload_limit;
  logic [7:0] limit_reg;
  logic       q_full;
  logic       q_push;
  rx_item_t   q_in;
  logic       q_pop;
  logic       q_valid;
  rx_item_t   q_out;
  rec_t       rec;

  assign pready = 1'b1;
  assign payload_limit = (paddr[2] == RegPayloadLimit);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= PayloadLimitReset;
    end else if (psel && penable && pwrite && payload_limit) begin
      limit_reg <= pwdata[7:0];
    end
  end

  assign prdata = payload_limit ? {24'd0, limit_reg} : 32'd0;

  atp_front u_front (
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  atp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_out)
  );

  atp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .payload_limit (limit_reg),
    .q_valid       (q_valid),
    .q_item        (q_out),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rec       (rec)
  );

  assign record_kind     = rec.kind;
  assign payload_char    = rec.pchar;
  assign payload_pos     = rec.ppos;
  assign line_status     = rec.status;
  assign sender_id       = rec.id;
  assign declared_length = rec.len;
  assign rssi_magnitude  = rec.rssi;
  assign snr_value       = rec.snr;
  assign error_seen      = rec.err;

endmodule

// File: sv/atp_front.sv
`timescale 1ns / 1ps
module atp_front import atp_pkg::*; (
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [7:0] rx_byte,
  input  logic     q_full,
  output logic     q_push,
  output rx_item_t q_item
);

  // sorts each character once into flags that the back end tests beside the raw character
  always_comb begin
    q_item.ch         = rx_byte;
    q_item.is_digit   = (rx_byte >= ChZero) && (rx_byte <= ChNine);
    q_item.is_comma   = (rx_byte == ChComma);
    q_item.is_newline = (rx_byte == ChNewline);
    q_item.is_plus    = (rx_byte == ChPlus);
    q_item.is_equals  = (rx_byte == ChEquals);
  end

  assign in_ready = !q_full && !rst;
  assign q_push   = in_valid && in_ready;

endmodule

// File: sv/atp_queue.sv
`timescale 1ns / 1ps
module atp_queue import atp_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rx_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output rx_item_t pop_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rx_item_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/atp_back.sv
`timescale 1ns / 1ps
module atp_back import atp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] payload_limit,
  input  logic       q_valid,
  input  rx_item_t   q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output rec_t       out_rec
);

  typedef enum logic [10:0] {
    PH_HUNT   = 11'b00000000001,
    PH_PREFIX = 11'b00000000010,
    PH_WAIT   = 11'b00000000100,
    PH_EQ     = 11'b00000001000,
    PH_ID     = 11'b00000010000,
    PH_LEN    = 11'b00000100000,
    PH_PAY    = 11'b00001000000,
    PH_SKIP   = 11'b00010000000,
    PH_RSSI   = 11'b00100000000,
    PH_SNR    = 11'b01000000000,
    PH_DONE   = 11'b10000000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  prefix_pos, prefix_pos_next;
  logic [4:0]  cands, cands_next;
  logic [15:0] id_acc, id_acc_next;
  logic [7:0]  len_acc, len_acc_next;
  logic [7:0]  rssi_acc, rssi_acc_next;
  logic [7:0]  snr_acc, snr_acc_next;
  logic [7:0]  copied, copied_next;
  logic [1:0]  ack_prog, ack_prog_next;
  logic        fmt_fault, fmt_fault_next;
  logic        err_sticky, err_sticky_next;
  logic        out_valid_next;

  logic [4:0]  pmatch;
  logic [4:0]  pdone;
  logic [2:0]  st;
  logic [7:0]  lim;
  logic [3:0]  dval;
  logic        res_valid;
  rec_t        res;

  assign q_pop = q_valid && (!out_valid || out_ready);
  assign dval  = q_item.ch[3:0];
  assign lim   = (len_acc < payload_limit) ? len_acc : payload_limit;

  // every live prefix checked against the current character in parallel
  always_comb begin
    for (int k = 0; k < NumPrefix; k++) begin
      pmatch[k] = cands[k] && (prefix_pos < prefix_len(k)) &&
                  (prefix_char(k, prefix_pos) == q_item.ch);
      pdone[k]  = pmatch[k] && ((prefix_pos + 4'd1) == prefix_len(k));
    end
  end

  // status at end of line
  always_comb begin
    priority if (phase == PH_PREFIX) begin
      st = StUnknown;
    end else if (phase == PH_SNR || phase == PH_DONE) begin
      st = (ack_prog == 2'd3) ? StRcvAck : StRcv;
    end else if (phase != PH_WAIT || fmt_fault) begin
      st = StRcvFmt;
    end else if (cands[CandOk]) begin
      st = StOk;
    end else if (cands[CandRcv]) begin
      st = StRcv;
    end else if (cands[CandErr]) begin
      st = StErr;
    end else if (cands[CandReady]) begin
      st = StReady;
    end else if (cands[CandFactory]) begin
      st = StFactory;
    end else begin
      st = StUnknown;
    end
  end

  always_comb begin
    phase_next      = phase;
    prefix_pos_next = prefix_pos;
    cands_next      = cands;
    id_acc_next     = id_acc;
    len_acc_next    = len_acc;
    rssi_acc_next   = rssi_acc;
    snr_acc_next    = snr_acc;
    copied_next     = copied;
    ack_prog_next   = ack_prog;
    fmt_fault_next  = fmt_fault;
    err_sticky_next = err_sticky;
    res_valid       = 1'b0;
    res             = '0;

    if (q_pop) begin
      if (phase == PH_HUNT) begin
        if (q_item.is_plus) begin
          phase_next      = PH_PREFIX;
          prefix_pos_next = 4'd1;
          cands_next      = 5'b11111;
          id_acc_next     = '0;
          len_acc_next    = '0;
          rssi_acc_next   = '0;
          snr_acc_next    = '0;
          copied_next     = '0;
          ack_prog_next   = '0;
          fmt_fault_next  = 1'b0;
        end
      end else if (q_item.is_newline) begin
        res_valid  = 1'b1;
        res.kind   = 1'b1;
        res.status = st;
        res.id     = id_acc;
        res.len    = len_acc;
        res.rssi   = rssi_acc;
        res.snr    = snr_acc;
        res.err    = err_sticky || (st == StErr);
        if (st == StErr) begin
          err_sticky_next = 1'b1;
        end
        phase_next = PH_HUNT;
      end else begin
        unique case (phase)
          PH_PREFIX: begin
            priority if (pdone != '0) begin
              cands_next = pdone;
              phase_next = pdone[CandRcv] ? PH_EQ : PH_WAIT;
            end else if (pmatch == '0) begin
              cands_next = '0;
              phase_next = PH_WAIT;
            end else begin
              cands_next = pmatch;
              if (prefix_pos < 4'd15) begin
                prefix_pos_next = prefix_pos + 4'd1;
              end
            end
          end
          PH_EQ: begin
            if (q_item.is_equals) begin
              phase_next = PH_ID;
            end
          end
          PH_ID: begin
            priority if (q_item.is_digit) begin
              id_acc_next = acc16(id_acc, dval);
            end else if (q_item.is_comma) begin
              phase_next = PH_LEN;
            end else begin
              fmt_fault_next = 1'b1;
              phase_next     = PH_WAIT;
            end
          end
          PH_LEN: begin
            priority if (q_item.is_digit) begin
              len_acc_next = acc8(len_acc, dval);
            end else if (q_item.is_comma) begin
              phase_next = PH_PAY;
            end else begin
              fmt_fault_next = 1'b1;
              phase_next     = PH_WAIT;
            end
          end
          PH_PAY: begin
            if (q_item.is_comma) begin
              phase_next = PH_SKIP;
            end else if (copied < lim) begin
              // ack check follows the first three copied characters
              if (copied < 8'd3 && {6'd0, ack_prog} == copied) begin
                if ((copied == 8'd0 && q_item.ch == ChA) ||
                    (copied == 8'd1 && q_item.ch == ChC) ||
                    (copied == 8'd2 && q_item.ch == ChK)) begin
                  ack_prog_next = ack_prog + 2'd1;
                end
              end
              copied_next = copied + 8'd1;
              res_valid   = 1'b1;
              res.kind    = 1'b0;
              res.pchar   = q_item.ch;
              res.ppos    = copied;
            end
          end
          PH_SKIP: begin
            phase_next = PH_RSSI;
          end
          PH_RSSI: begin
            priority if (q_item.is_digit) begin
              rssi_acc_next = acc8(rssi_acc, dval);
            end else if (q_item.is_comma) begin
              phase_next = PH_SNR;
            end else begin
              fmt_fault_next = 1'b1;
              phase_next     = PH_WAIT;
            end
          end
          PH_SNR: begin
            if (q_item.is_digit) begin
              snr_acc_next = acc8(snr_acc, dval);
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (q_pop) begin
      out_valid_next = res_valid;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      prefix_pos <= '0;
      cands      <= 5'b11111;
      id_acc     <= '0;
      len_acc    <= '0;
      rssi_acc   <= '0;
      snr_acc    <= '0;
      copied     <= '0;
      ack_prog   <= '0;
      fmt_fault  <= 1'b0;
      err_sticky <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      prefix_pos <= prefix_pos_next;
      cands      <= cands_next;
      id_acc     <= id_acc_next;
      len_acc    <= len_acc_next;
      rssi_acc   <= rssi_acc_next;
      snr_acc    <= snr_acc_next;
      copied     <= copied_next;
      ack_prog   <= ack_prog_next;
      fmt_fault  <= fmt_fault_next;
      err_sticky <= err_sticky_next;
      out_valid  <= out_valid_next;
    end
  end

  // output record register, loaded only when a record is produced
  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_rec <= res;
    end
  end

endmodule
